/* src/ljp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ljp_pkg
// Shared types, constants and saturating fixed-point helpers of the
// Lennard-Jones pair force block.
// ----------------------------------------------------------------------------
package ljp_pkg;

	localparam int MAX_PARTICLES_DEF = 64;
	localparam int QUEUE_DEPTH       = 2;
	localparam int ADDR_W            = 5;
	localparam int OUT_DATA_W        = 232;

	localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] SAT_MIN = 32'sh80000000;
	localparam logic signed [67:0] Q_ONE   = 68'sd65536;

	// register indexes
	localparam logic [2:0] REG_BOX_LENGTH   = 3'd0;
	localparam logic [2:0] REG_CUTOFF_SQ    = 3'd1;
	localparam logic [2:0] REG_THREE_D      = 3'd2;
	localparam logic [2:0] REG_ENERGY_SHIFT = 3'd3;
	localparam logic [2:0] REG_ENERGY_TAIL  = 3'd4;
	localparam logic [2:0] REG_PRESS_TAIL   = 3'd5;
	localparam logic [2:0] REG_KIN_PRESS    = 3'd6;
	localparam logic [2:0] REG_INV_DIM_VOL  = 3'd7;

	typedef struct packed {
		logic [23:0]        box_length;
		logic [31:0]        cutoff_sq;
		logic               three_d;
		logic signed [31:0] energy_shift;
		logic signed [31:0] energy_tail;
		logic signed [31:0] pressure_tail;
		logic [30:0]        kinetic_pressure;
		logic [31:0]        inv_dim_volume;
	} cfg_t;

	// one particle on its way from the loader to the engine
	typedef struct packed {
		logic [15:0] pos_z;
		logic [15:0] pos_y;
		logic [15:0] pos_x;
		logic        store;
		logic        last;
		logic        dropped;
	} entry_t;

	typedef struct packed {
		logic               ovf;
		logic signed [31:0] v;
	} sat_t;

	function automatic sat_t sat32(input logic signed [67:0] v);
		sat_t r;
		if (v > 68'(SAT_MAX)) begin
			r.ovf = 1'b1;
			r.v   = SAT_MAX;
		end else if (v < 68'(SAT_MIN)) begin
			r.ovf = 1'b1;
			r.v   = SAT_MIN;
		end else begin
			r.ovf = 1'b0;
			r.v   = v[31:0];
		end
		return r;
	endfunction

	// product back to Q16.16, floor, saturated
	function automatic sat_t qmul(input logic signed [65:0] p);
		logic signed [65:0] s;
		s = p >>> 16;
		return sat32(68'(s));
	endfunction

endpackage
`default_nettype wire

/* src/ljp_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ljp_fifo
// Short particle queue between the loader and the pair engine.
// ----------------------------------------------------------------------------
module ljp_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire ljp_pkg::entry_t push_data,
	output logic                 full,
	input  wire logic            pop,
	output ljp_pkg::entry_t      pop_data,
	output logic                 valid
);

	localparam int D  = ljp_pkg::QUEUE_DEPTH;
	localparam int PW = $clog2(D);
	localparam int CW = $clog2(D + 1);

	ljp_pkg::entry_t slot_q [D];
	logic [PW-1:0]   wr_q, rd_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push, do_pop;

	assign full     = (cnt_q == CW'(D));
	assign valid    = (cnt_q != '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && valid;
	assign pop_data = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == PW'(D - 1)) ? '0 : wr_q + PW'(1);
			if (do_pop) rd_q <= (rd_q == PW'(D - 1)) ? '0 : rd_q + PW'(1);
			if (do_push && !do_pop) cnt_q <= cnt_q + CW'(1);
			else if (do_pop && !do_push) cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_q] <= push_data;
	end

endmodule
`default_nettype wire

/* src/ljp_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ljp_front
// Particle loader: counts the batch, drops particles past capacity and
// queues the rest, and always the batch's last particle, for the pair engine.
// ----------------------------------------------------------------------------
module ljp_front #(
	parameter int MAX_PARTICLES = ljp_pkg::MAX_PARTICLES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,   // pos_x, pos_y, pos_z
	input  wire logic        s_tlast,   // last_particle
	input  wire logic        q_full,
	output logic             q_push,
	output ljp_pkg::entry_t  q_data
);

	localparam int CW = $clog2(MAX_PARTICLES + 1);

	logic [CW-1:0] cnt_q;
	logic          drop_q;
	logic          acc, store;

	assign s_tready = !q_full;
	assign acc      = s_tvalid && s_tready;
	assign store    = (cnt_q < CW'(MAX_PARTICLES));
	assign q_push   = acc && (store || s_tlast);

	always_comb begin
		q_data.pos_x   = s_tdata[15:0];
		q_data.pos_y   = s_tdata[31:16];
		q_data.pos_z   = s_tdata[47:32];
		q_data.store   = store;
		q_data.last    = s_tlast;
		q_data.dropped = drop_q || !store;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			drop_q <= 1'b0;
		end else if (acc) begin
			if (s_tlast) begin
				cnt_q  <= '0;
				drop_q <= 1'b0;
			end else if (store) begin
				cnt_q <= cnt_q + CW'(1);
			end else begin
				drop_q <= 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

/* src/ljp_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ljp_back
// Pair engine: stores positions, walks all pairs through a shared multiplier
// and a bit-serial reciprocal divider, then streams one result per particle.
// ----------------------------------------------------------------------------
module ljp_back #(
	parameter int MAX_PARTICLES = ljp_pkg::MAX_PARTICLES_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire ljp_pkg::cfg_t   cfg,
	input  wire logic            q_valid,
	input  wire ljp_pkg::entry_t q_data,
	output logic                 q_pop,
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	output logic [231:0]         m_tdata,
	output logic                 m_tlast,
	output logic                 m_tuser
);

	localparam int AW = $clog2(MAX_PARTICLES);
	localparam int CW = $clog2(MAX_PARTICLES + 1);

	typedef enum logic [19:0] {
		ST_LOAD  = 20'h00001,
		ST_PRD   = 20'h00002,
		ST_DX    = 20'h00004,
		ST_SQ    = 20'h00008,
		ST_R2    = 20'h00010,
		ST_DIV   = 20'h00020,
		ST_M1    = 20'h00040,
		ST_M2    = 20'h00080,
		ST_M3    = 20'h00100,
		ST_M4    = 20'h00200,
		ST_M5    = 20'h00400,
		ST_MF    = 20'h00800,
		ST_MU    = 20'h01000,
		ST_NEXT  = 20'h02000,
		ST_ROWRD = 20'h04000,
		ST_ROWWR = 20'h08000,
		ST_FIN1  = 20'h10000,
		ST_FIN2  = 20'h20000,
		ST_ORD   = 20'h40000,
		ST_OWAIT = 20'h80000
	} state_t;

	state_t          state_q;
	logic [AW-1:0]   i_q, j_q, k_q;
	logic [CW-1:0]   n_q;
	logic [1:0]      ax_q;
	logic [5:0]      div_cnt_q;
	logic            drop_q, satf_q;
	logic [MAX_PARTICLES-1:0] frc_vld_q;

	// memories
	logic [47:0]     pos_mem [MAX_PARTICLES];
	logic [95:0]     frc_mem [MAX_PARTICLES];
	logic [47:0]     pos_i_q, pos_j_q;
	logic [95:0]     frc_rd_q;
	logic            frc_rdv_q;

	// datapath
	logic signed [23:0] dx_q [3];
	logic [46:0]        sq_q [3];
	logic [48:0]        r2_q, quo_q;
	logic [48:0]        rem_q;
	logic signed [31:0] ir2_q, p_q, dr6_q, t_q, fr_q, fs_q;
	logic signed [31:0] fi_q [3];
	logic signed [31:0] fj_q [3];
	logic signed [31:0] e_q, vir_q, es_q, ef_q, pr_q;
	logic [11:0]        pc_q;

	logic               m_valid_q, m_last_q, m_ovf_q;
	logic [231:0]       m_data_q;

	// combinational
	logic signed [32:0] ma, mb;
	logic signed [65:0] prod;
	ljp_pkg::sat_t      qm;
	logic [CW-1:0]      n_new;
	logic               last_j, last_row, out_free, out_load, ax_end;
	logic signed [23:0] dx_c [3];
	logic [46:0]        sq_c [3];
	logic [48:0]        r2_c;
	logic [49:0]        rem_sh;
	logic               qbit;
	logic [48:0]        rem_nx, quo_nx;
	logic [95:0]        frc_rd_eff;
	logic [AW-1:0]      frc_ra;
	logic               frc_we;
	logic [AW-1:0]      frc_wa;
	logic [95:0]        frc_wd;
	ljp_pkg::sat_t      t_c, vir_c, fi_c, fj_c, u_c, e_c, es_c, ef_c, pr_c;
	ljp_pkg::sat_t      rw_c [3];

	assign n_new    = n_q + CW'(q_data.store);
	assign last_j   = (CW'(j_q) + CW'(1) == n_q);
	assign last_row = (CW'(i_q) + CW'(2) >= n_q);
	assign ax_end   = (ax_q == (cfg.three_d ? 2'd2 : 2'd1));
	assign out_free = !m_valid_q || m_tready;
	assign out_load = (state_q == ST_OWAIT) && out_free;
	assign q_pop    = (state_q == ST_LOAD) && q_valid;
	assign frc_rd_eff = frc_rdv_q ? frc_rd_q : '0;

	// shared multiplier operand select
	always_comb begin
		unique case (state_q)
			ST_M1:   begin ma = 33'(ir2_q); mb = 33'(ir2_q); end
			ST_M2:   begin ma = 33'(p_q);   mb = 33'(ir2_q); end
			ST_M4:   begin ma = 33'(dr6_q); mb = 33'(t_q);   end
			ST_M5:   begin ma = 33'(fr_q);  mb = 33'(ir2_q); end
			ST_MF:   begin ma = 33'(dx_q[ax_q]); mb = 33'(fs_q); end
			ST_MU:   begin ma = 33'(dr6_q); mb = 33'(dr6_q) - 33'sd65536; end
			ST_FIN1: begin ma = $signed({21'b0, pc_q}); mb = 33'(cfg.energy_shift); end
			ST_FIN2: begin ma = 33'(vir_q); mb = $signed({1'b0, cfg.inv_dim_volume}); end
			default: begin ma = '0; mb = '0; end
		endcase
		prod = 66'(ma) * 66'(mb);
		qm   = ljp_pkg::qmul(prod);
	end

	// minimum image, squares, distance, divider step
	always_comb begin
		logic signed [15:0] d;
		logic signed [40:0] dp;
		r2_c = '0;
		for (int k = 0; k < 3; k++) begin
			d  = $signed(pos_i_q[16*k +: 16] - pos_j_q[16*k +: 16]);
			dp = 41'(d) * $signed({16'b0, cfg.box_length});
			dx_c[k] = (k == 2 && !cfg.three_d) ? 24'sd0 : 24'(dp >>> 16);
			sq_c[k] = 47'(48'(dx_q[k]) * 48'(dx_q[k]));
			r2_c    = r2_c + 49'(sq_q[k]);
		end
		rem_sh = {rem_q, (div_cnt_q == 6'd48)};
		qbit   = (rem_sh >= {1'b0, r2_q});
		rem_nx = qbit ? 49'(rem_sh - {1'b0, r2_q}) : rem_sh[48:0];
		quo_nx = {quo_q[47:0], qbit};
	end

	// scalar updates
	always_comb begin
		logic signed [65:0] us;
		us    = prod >>> 16;
		t_c   = ljp_pkg::sat32((68'(dr6_q) <<< 5) + (68'(dr6_q) <<< 4) - 24 * ljp_pkg::Q_ONE);
		vir_c = ljp_pkg::sat32(68'(vir_q) + 68'(fr_q));
		fi_c  = ljp_pkg::sat32(68'(fi_q[ax_q]) + 68'(qm.v));
		fj_c  = ljp_pkg::sat32(68'(fj_q[ax_q]) - 68'(qm.v));
		u_c   = ljp_pkg::sat32(68'(us) <<< 2);
		e_c   = ljp_pkg::sat32(68'(e_q) + 68'(u_c.v));
		es_c  = ljp_pkg::sat32(68'(e_q) - 68'(prod));
		ef_c  = ljp_pkg::sat32(68'(e_q) + 68'(cfg.energy_tail));
		pr_c  = ljp_pkg::sat32(68'({1'b0, cfg.kinetic_pressure}) + 68'(prod >>> 32)
			+ 68'(cfg.pressure_tail));
		for (int k = 0; k < 3; k++)
			rw_c[k] = ljp_pkg::sat32(68'($signed(frc_rd_eff[32*k +: 32])) + 68'(fi_q[k]));
	end

	// force memory port
	always_comb begin
		frc_we = 1'b0;
		frc_wa = j_q;
		frc_wd = {fj_q[2], fj_q[1], fj_q[0]};
		if (state_q == ST_MU) begin
			frc_we = 1'b1;
		end else if (state_q == ST_ROWWR) begin
			frc_we = 1'b1;
			frc_wa = i_q;
			frc_wd = {rw_c[2].v, rw_c[1].v, rw_c[0].v};
		end
		// the result read is held while the output waits
		priority case (1'b1)
			state_q == ST_ROWRD:                        frc_ra = i_q;
			state_q == ST_ORD || state_q == ST_OWAIT: frc_ra = k_q;
			default:                                    frc_ra = j_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_data.store)
			pos_mem[n_q[AW-1:0]] <= {q_data.pos_z, q_data.pos_y, q_data.pos_x};
		pos_i_q <= pos_mem[i_q];
		pos_j_q <= pos_mem[j_q];
		if (frc_we) frc_mem[frc_wa] <= frc_wd;
		frc_rd_q <= frc_mem[frc_ra];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			i_q       <= '0;
			j_q       <= '0;
			k_q       <= '0;
			n_q       <= '0;
			ax_q      <= '0;
			div_cnt_q <= '0;
			drop_q    <= 1'b0;
			satf_q    <= 1'b0;
			frc_vld_q <= '0;
			frc_rdv_q <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			frc_rdv_q <= frc_vld_q[frc_ra];
			if (frc_we) frc_vld_q[frc_wa] <= 1'b1;
			if (out_load) m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;
			unique case (state_q)
				ST_LOAD: begin
					if (q_pop) begin
						n_q <= n_new;
						if (q_data.last) begin
							drop_q    <= q_data.dropped;
							satf_q    <= 1'b0;
							frc_vld_q <= '0;
							i_q       <= '0;
							j_q       <= AW'(1);
							state_q   <= (n_new < CW'(2)) ? ST_FIN1 : ST_PRD;
						end
					end
				end
				ST_PRD: state_q <= ST_DX;
				ST_DX:  state_q <= ST_SQ;
				ST_SQ:  state_q <= ST_R2;
				ST_R2: begin
					div_cnt_q <= 6'd48;
					if (r2_c > {1'b0, cfg.cutoff_sq, 16'b0}) begin
						state_q <= ST_NEXT;
					end else if (r2_c == '0) begin
						satf_q  <= 1'b1;
						state_q <= ST_M1;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q - 6'd1;
					if (div_cnt_q == '0) begin
						if (quo_nx[48:31] != '0) satf_q <= 1'b1;
						state_q <= ST_M1;
					end
				end
				ST_M1: begin satf_q <= satf_q | qm.ovf; state_q <= ST_M2; end
				ST_M2: begin satf_q <= satf_q | qm.ovf; state_q <= ST_M3; end
				ST_M3: begin satf_q <= satf_q | t_c.ovf; state_q <= ST_M4; end
				ST_M4: begin satf_q <= satf_q | qm.ovf; state_q <= ST_M5; end
				ST_M5: begin
					satf_q  <= satf_q | qm.ovf | vir_c.ovf;
					ax_q    <= '0;
					state_q <= ST_MF;
				end
				ST_MF: begin
					satf_q <= satf_q | qm.ovf | fi_c.ovf | fj_c.ovf;
					ax_q   <= ax_q + 2'd1;
					if (ax_end) state_q <= ST_MU;
				end
				ST_MU: begin
					satf_q  <= satf_q | u_c.ovf | e_c.ovf;
					state_q <= ST_NEXT;
				end
				ST_NEXT: begin
					if (last_j) begin
						state_q <= ST_ROWRD;
					end else begin
						j_q     <= j_q + AW'(1);
						state_q <= ST_PRD;
					end
				end
				ST_ROWRD: state_q <= ST_ROWWR;
				ST_ROWWR: begin
					satf_q <= satf_q | rw_c[0].ovf | rw_c[1].ovf | rw_c[2].ovf;
					i_q    <= i_q + AW'(1);
					j_q    <= i_q + AW'(2);
					state_q <= last_row ? ST_FIN1 : ST_PRD;
				end
				ST_FIN1: begin
					satf_q  <= satf_q | es_c.ovf | ef_c.ovf;
					state_q <= ST_FIN2;
				end
				ST_FIN2: begin
					satf_q  <= satf_q | pr_c.ovf;
					k_q     <= '0;
					state_q <= ST_ORD;
				end
				ST_ORD: state_q <= ST_OWAIT;
				ST_OWAIT: begin
					if (out_free) begin
						k_q <= k_q + AW'(1);
						if (CW'(k_q) + CW'(1) == n_q) begin
							n_q     <= '0;
							state_q <= ST_LOAD;
						end else begin
							state_q <= ST_ORD;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_LOAD: begin
				e_q   <= '0;
				vir_q <= '0;
				pc_q  <= '0;
				for (int k = 0; k < 3; k++) fi_q[k] <= '0;
			end
			ST_DX: begin
				for (int k = 0; k < 3; k++) begin
					dx_q[k] <= dx_c[k];
					fj_q[k] <= $signed(frc_rd_eff[32*k +: 32]);
				end
			end
			ST_SQ: for (int k = 0; k < 3; k++) sq_q[k] <= sq_c[k];
			ST_R2: begin
				r2_q  <= r2_c;
				rem_q <= '0;
				quo_q <= '0;
				ir2_q <= ljp_pkg::SAT_MAX;
			end
			ST_DIV: begin
				rem_q <= rem_nx;
				quo_q <= quo_nx;
				if (div_cnt_q == '0)
					ir2_q <= (quo_nx[48:31] != '0) ? ljp_pkg::SAT_MAX : $signed(quo_nx[31:0]);
			end
			ST_M1: p_q   <= qm.v;
			ST_M2: dr6_q <= qm.v;
			ST_M3: t_q   <= t_c.v;
			ST_M4: fr_q  <= qm.v;
			ST_M5: begin
				vir_q <= vir_c.v;
				fs_q  <= qm.v;
			end
			ST_MF: begin
				fi_q[ax_q] <= fi_c.v;
				fj_q[ax_q] <= fj_c.v;
			end
			ST_MU: begin
				e_q  <= e_c.v;
				pc_q <= pc_q + 12'd1;
			end
			ST_ROWWR: for (int k = 0; k < 3; k++) fi_q[k] <= '0;
			ST_FIN1: begin
				es_q <= es_c.v;
				ef_q <= ef_c.v;
			end
			ST_FIN2: pr_q <= pr_c.v;
			ST_OWAIT: begin
				if (out_free) begin
					m_data_q <= {2'b0, pr_q, vir_q, ef_q, es_q,
						cfg.three_d ? frc_rd_eff[95:64] : 32'b0,
						frc_rd_eff[63:32], frc_rd_eff[31:0], 6'(k_q)};
					m_last_q <= (CW'(k_q) + CW'(1) == n_q);
					m_ovf_q  <= drop_q || satf_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;
	assign m_tuser  = m_ovf_q;

endmodule
`default_nettype wire

/* src/lj_pair_force_pbc.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lj_pair_force_pbc
// Lennard-Jones all-pairs force and energy evaluation with minimum-image
// periodic boundaries and squared cutoff, 2D or 3D.
// ----------------------------------------------------------------------------
// sequence: particles are stored as the queue delivers them; a pair inside the
//   cutoff runs through the 49-step bit-serial reciprocal divider (skipped for
//   a zero distance) and the shared multiplier, a pair outside it is skipped; a
//   force read and write-back end each row, then results are read out in turn
// throughput: one batch at a time; loading of the next batch proceeds until
//   the two-entry queue fills
// reset: arst_n clears all control state and loads the register defaults
module lj_pair_force_pbc #(
	parameter int MAX_PARTICLES = ljp_pkg::MAX_PARTICLES_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [ljp_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]               pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	input  wire logic [47:0]               s_tdata,  // pos_x, pos_y, pos_z
	input  wire logic                      s_tlast,  // last_particle
	output logic                           m_tvalid,
	input  wire logic                      m_tready,
	// particle_index, force_x, force_y, force_z, energy_shifted, energy_full,
	// virial, pressure, zero pad
	output logic [ljp_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic                           m_tlast,  // last_result
	output logic                           m_tuser   // overflow
);

	ljp_pkg::cfg_t   cfg_q;
	ljp_pkg::entry_t q_in, q_out;
	logic            q_push, q_full, q_pop, q_valid;
	logic            wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.box_length       <= 24'd1572864;
			cfg_q.cutoff_sq        <= 32'd409600;
			cfg_q.three_d          <= 1'b1;
			cfg_q.energy_shift     <= '0;
			cfg_q.energy_tail      <= '0;
			cfg_q.pressure_tail    <= '0;
			cfg_q.kinetic_pressure <= '0;
			cfg_q.inv_dim_volume   <= '0;
		end else if (wr_en) begin
			unique case (paddr[4:2])
				ljp_pkg::REG_BOX_LENGTH:   cfg_q.box_length       <= pwdata[23:0];
				ljp_pkg::REG_CUTOFF_SQ:    cfg_q.cutoff_sq        <= pwdata;
				ljp_pkg::REG_THREE_D:      cfg_q.three_d          <= pwdata[0];
				ljp_pkg::REG_ENERGY_SHIFT: cfg_q.energy_shift     <= pwdata;
				ljp_pkg::REG_ENERGY_TAIL:  cfg_q.energy_tail      <= pwdata;
				ljp_pkg::REG_PRESS_TAIL:   cfg_q.pressure_tail    <= pwdata;
				ljp_pkg::REG_KIN_PRESS:    cfg_q.kinetic_pressure <= pwdata[30:0];
				ljp_pkg::REG_INV_DIM_VOL:  cfg_q.inv_dim_volume   <= pwdata;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			ljp_pkg::REG_BOX_LENGTH:   prdata = {8'b0, cfg_q.box_length};
			ljp_pkg::REG_CUTOFF_SQ:    prdata = cfg_q.cutoff_sq;
			ljp_pkg::REG_THREE_D:      prdata = {31'b0, cfg_q.three_d};
			ljp_pkg::REG_ENERGY_SHIFT: prdata = cfg_q.energy_shift;
			ljp_pkg::REG_ENERGY_TAIL:  prdata = cfg_q.energy_tail;
			ljp_pkg::REG_PRESS_TAIL:   prdata = cfg_q.pressure_tail;
			ljp_pkg::REG_KIN_PRESS:    prdata = {1'b0, cfg_q.kinetic_pressure};
			ljp_pkg::REG_INV_DIM_VOL:  prdata = cfg_q.inv_dim_volume;
		endcase
	end

	ljp_front #(.MAX_PARTICLES(MAX_PARTICLES)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_in)
	);

	ljp_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_out),
		.valid     (q_valid)
	);

	ljp_back #(.MAX_PARTICLES(MAX_PARTICLES)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (q_valid),
		.q_data   (q_out),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule
`default_nettype wire

/* tb/sv/lj_pair_force_pbc_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lj_pair_force_pbc_tb
// Loads batches of particle positions over the input stream and checks every
// per-particle force and energy result against an in-bench fixed-point model
// of the minimum-image Lennard-Jones evaluation, across several register
// settings, with random stalls on both streams.
// ----------------------------------------------------------------------------
module lj_pair_force_pbc_tb;

	localparam int NCAP      = 64;
	localparam int QUIET_MAX = 600000;
	localparam int DRAIN     = 60;

	typedef struct {
		logic [15:0] x, y, z;
		logic        last;
	} particle_t;

	typedef struct {
		logic [5:0]  idx;
		logic [31:0] fx, fy, fz, e_shift, e_full, vir, press;
		logic        ovf, last;
	} lj_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ljp_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [47:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [ljp_pkg::OUT_DATA_W-1:0] m_tdata;
	logic m_tlast, m_tuser;

	lj_pair_force_pbc uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast), .m_tuser(m_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// model copy of the registers
	longint box_len, cut_sq, energy_shift, energy_tail, press_tail, kin_press, inv_dv;
	bit     mode_3d;

	// model copy of the batch state
	logic [15:0] pos_mem [NCAP][3];
	int     loaded;
	bit     lost_particle;
	bit     sat_hit;
	longint frc [NCAP][3];

	particle_t  pending_q [$];
	lj_result_t expected_q [$];

	int errors = 0;
	int n_results = 0;
	int n_batches = 0;
	int n_items = 0;
	int n_settings = 0;
	int idle_pct = 20;
	int hold_req = 0;
	int hold_done = 0;
	int hold_len = 0;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		errors++;
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
	endtask

	function automatic longint sat32(input longint v);
		if (v > 64'sd2147483647) begin
			sat_hit = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			sat_hit = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic longint qprod(input longint a, input longint b);
		return sat32((a * b) >>> 16);
	endfunction

	// all-pairs sweep over the loaded batch, then one expectation per particle
	task automatic lj_batch();
		int     dims, n;
		longint dx [3];
		longint acc [3];
		longint r2, ir2, dr6, t, fr, fs, u, tmp, esum, vsum, es, ef, pr;
		int     pairs;
		logic [15:0] dw;
		lj_result_t r;
		dims = mode_3d ? 3 : 2;
		n = loaded;
		sat_hit = 1'b0;
		esum = 0;
		vsum = 0;
		pairs = 0;
		foreach (frc[i, k]) frc[i][k] = 0;
		for (int i = 0; i + 1 < n; i++) begin
			acc = '{0, 0, 0};
			for (int j = i + 1; j < n; j++) begin
				r2 = 0;
				dx = '{0, 0, 0};
				for (int k = 0; k < dims; k++) begin
					dw = pos_mem[i][k] - pos_mem[j][k];
					dx[k] = (longint'($signed(dw)) * box_len) >>> 16;
					r2 += dx[k] * dx[k];
				end
				if (r2 > (cut_sq << 16)) continue;
				if (r2 == 0) begin
					sat_hit = 1'b1;
					ir2 = 64'sd2147483647;
				end else begin
					ir2 = sat32(longint'((64'd1 << 48) / 64'(r2)));
				end
				dr6 = qprod(qprod(ir2, ir2), ir2);
				t = sat32(48 * dr6 - 24 * 65536);
				fr = qprod(dr6, t);
				vsum = sat32(vsum + fr);
				fs = qprod(fr, ir2);
				for (int k = 0; k < dims; k++) begin
					tmp = qprod(dx[k], fs);
					acc[k] = sat32(acc[k] + tmp);
					frc[j][k] = sat32(frc[j][k] - tmp);
				end
				u = sat32(4 * ((dr6 * (dr6 - 65536)) >>> 16));
				esum = sat32(esum + u);
				pairs = (pairs + 1) & 12'hfff;
			end
			for (int k = 0; k < 3; k++) frc[i][k] = sat32(frc[i][k] + acc[k]);
		end
		es = sat32(esum - longint'(pairs) * energy_shift);
		ef = sat32(esum + energy_tail);
		pr = (vsum * inv_dv) >>> 32;
		pr = sat32(kin_press + pr + press_tail);
		for (int i = 0; i < n; i++) begin
			r.idx = 6'(i);
			r.fx = frc[i][0][31:0];
			r.fy = frc[i][1][31:0];
			r.fz = mode_3d ? frc[i][2][31:0] : 32'd0;
			r.e_shift = es[31:0];
			r.e_full = ef[31:0];
			r.vir = vsum[31:0];
			r.press = pr[31:0];
			r.ovf = lost_particle | sat_hit;
			r.last = (i + 1 == n);
			expected_q.push_back(r);
		end
		loaded = 0;
		lost_particle = 1'b0;
		n_batches++;
	endtask

	task automatic particle_in(input particle_t p);
		if (loaded < NCAP) begin
			pos_mem[loaded][0] = p.x;
			pos_mem[loaded][1] = p.y;
			pos_mem[loaded][2] = p.z;
			loaded++;
		end else begin
			lost_particle = 1'b1;
		end
		n_items++;
		if (p.last) lj_batch();
	endtask

	// input driver
	int src_gap = 0;
	always @(posedge clk) begin
		particle_t p;
		logic nv;
		nv = s_tvalid;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				particle_in(pending_q.pop_front());
				nv = 1'b0;
			end
			if (!nv) begin
				if (src_gap > 0) begin
					src_gap--;
				end else if (pending_q.size() > 0) begin
					if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
						src_gap = $urandom_range(1, 9) - 1;
					end else begin
						p = pending_q[0];
						s_tdata <= {p.z, p.y, p.x};
						s_tlast <= p.last;
						nv = 1'b1;
					end
				end
			end
		end
		s_tvalid <= nv;
	end

	// result monitor and receiver stalls
	int sink_gap = 0;
	int hold_left = 0;
	always @(posedge clk) begin
		lj_result_t e;
		logic nr;
		nr = 1'b1;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				n_results++;
				if (expected_q.size() == 0) begin
					errors++;
					$display("unexpected result transfer at %0t", $realtime);
				end else begin
					e = expected_q.pop_front();
					if (m_tdata[5:0] != e.idx) report("particle_index", 32'(m_tdata[5:0]), 32'(e.idx));
					if (m_tdata[37:6] != e.fx) report("force_x", m_tdata[37:6], e.fx);
					if (m_tdata[69:38] != e.fy) report("force_y", m_tdata[69:38], e.fy);
					if (m_tdata[101:70] != e.fz) report("force_z", m_tdata[101:70], e.fz);
					if (m_tdata[133:102] != e.e_shift)
						report("energy_shifted", m_tdata[133:102], e.e_shift);
					if (m_tdata[165:134] != e.e_full) report("energy_full", m_tdata[165:134], e.e_full);
					if (m_tdata[197:166] != e.vir) report("virial", m_tdata[197:166], e.vir);
					if (m_tdata[229:198] != e.press) report("pressure", m_tdata[229:198], e.press);
					if (m_tuser != e.ovf) report("overflow", 32'(m_tuser), 32'(e.ovf));
					if (m_tlast != e.last) report("last_result", 32'(m_tlast), 32'(e.last));
				end
			end
			if (hold_req != hold_done) begin
				hold_done = hold_req;
				hold_left = hold_len;
			end
			if (hold_left > 0) begin
				hold_left--;
				nr = 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				nr = 1'b0;
			end else if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
				sink_gap = $urandom_range(1, 9) - 1;
				nr = 1'b0;
			end
		end else begin
			nr = 1'b0;
		end
		m_tready <= nr;
	end

	// watchdog on cycles without any transfer
	int quiet = 0;
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_MAX) begin
			$display("lj_pair_force_pbc_tb failed");
			$display("timeout: no transfer for %0d cycles", QUIET_MAX);
			$finish;
		end
	end

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			ljp_pkg::REG_BOX_LENGTH:   box_len = longint'(val[23:0]);
			ljp_pkg::REG_CUTOFF_SQ:    cut_sq = longint'(val);
			ljp_pkg::REG_THREE_D:      mode_3d = val[0];
			ljp_pkg::REG_ENERGY_SHIFT: energy_shift = longint'($signed(val));
			ljp_pkg::REG_ENERGY_TAIL:  energy_tail = longint'($signed(val));
			ljp_pkg::REG_PRESS_TAIL:   press_tail = longint'($signed(val));
			ljp_pkg::REG_KIN_PRESS:    kin_press = longint'(val[30:0]);
			default:                   inv_dv = longint'(val);
		endcase
	endtask

	task automatic all_regs(input logic [23:0] bl, input logic [31:0] cs, input logic td,
			input logic [31:0] sh, input logic [31:0] et, input logic [31:0] pt,
			input logic [30:0] kp, input logic [31:0] iv);
		reg_write(ljp_pkg::REG_BOX_LENGTH, 32'(bl));
		reg_write(ljp_pkg::REG_CUTOFF_SQ, cs);
		reg_write(ljp_pkg::REG_THREE_D, 32'(td));
		reg_write(ljp_pkg::REG_ENERGY_SHIFT, sh);
		reg_write(ljp_pkg::REG_ENERGY_TAIL, et);
		reg_write(ljp_pkg::REG_PRESS_TAIL, pt);
		reg_write(ljp_pkg::REG_KIN_PRESS, 32'(kp));
		reg_write(ljp_pkg::REG_INV_DIM_VOL, iv);
		n_settings++;
	endtask

	task automatic wait_idle();
		while (pending_q.size() > 0 || s_tvalid || expected_q.size() > 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic put(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z,
			input logic last);
		particle_t p;
		p.x = x;
		p.y = y;
		p.z = z;
		p.last = last;
		pending_q.push_back(p);
	endtask

	// a batch of n particles, clustered so that many pairs fall inside the cutoff
	task automatic batch(input int n, input int spread);
		logic [15:0] cx, cy, cz;
		cx = 16'($urandom);
		cy = 16'($urandom);
		cz = 16'($urandom);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9) == 0)
				put(16'($urandom), 16'($urandom), 16'($urandom), i == n - 1);
			else
				put(cx + 16'($urandom_range(0, 2 * spread) - spread),
					cy + 16'($urandom_range(0, 2 * spread) - spread),
					cz + 16'($urandom_range(0, 2 * spread) - spread), i == n - 1);
		end
	endtask

	task automatic random_batches(input int items);
		int k, n;
		k = 0;
		while (k < items) begin
			n = ($urandom_range(15) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 7);
			batch(n, $urandom_range(500, 6000));
			k += n;
		end
	endtask

	initial begin
		box_len = 1572864;
		cut_sq = 409600;
		mode_3d = 1'b1;
		energy_shift = 0;
		energy_tail = 0;
		press_tail = 0;
		kin_press = 0;
		inv_dv = 0;
		loaded = 0;
		lost_particle = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: single particle, coincident pair, wrapping extremes, close pairs
		all_regs(24'd1572864, 32'd409600, 1'b1, 32'hfffe_1c00, 32'h0000_8000, 32'hffff_0000,
			31'd98304, 32'h0aaa_aaab);
		put(16'h1234, 16'h5678, 16'h9abc, 1'b1);
		put(16'h0100, 16'h0100, 16'h0100, 1'b0);
		put(16'h0100, 16'h0100, 16'h0100, 1'b1);
		put(16'h0000, 16'h0000, 16'h0000, 1'b0);
		put(16'hffff, 16'hffff, 16'hffff, 1'b0);
		put(16'h8000, 16'h8000, 16'h8000, 1'b0);
		put(16'h7fff, 16'h0000, 16'hffff, 1'b1);
		put(16'h4000, 16'h4000, 16'h4000, 1'b0);
		put(16'h4bf0, 16'h4000, 16'h4000, 1'b0);
		put(16'h4000, 16'h4c00, 16'h4000, 1'b0);
		put(16'h4000, 16'h4000, 16'h3500, 1'b1);
		wait_idle();
		// two dimensions: z must be ignored
		all_regs(24'd655360, 32'd1048576, 1'b0, 32'h0001_0000, 32'h8000_0000, 32'h7fff_ffff,
			31'h7fff_ffff, 32'hffff_ffff);
		put(16'h1000, 16'h2000, 16'hffff, 1'b0);
		put(16'h1a00, 16'h2000, 16'h0000, 1'b0);
		put(16'h1000, 16'h2a00, 16'h5555, 1'b0);
		put(16'h1100, 16'h2100, 16'haaaa, 1'b1);
		wait_idle();
		// extreme registers: smallest box, zero cutoff, then largest of each
		all_regs(24'd1, 32'd0, 1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'd0, 32'd0);
		batch(4, 3000);
		wait_idle();
		all_regs(24'hffffff, 32'hffff_ffff, 1'b1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			31'h7fff_ffff, 32'hffff_ffff);
		batch(5, 30000);
		wait_idle();

		// capacity: two particles beyond the store are dropped
		all_regs(24'd1572864, 32'd409600, 1'b1, 32'hfffe_1c00, 32'd0, 32'd0, 31'd50000,
			32'h0400_0000);
		for (int i = 0; i < NCAP + 2; i++)
			put(16'($urandom), 16'($urandom), 16'($urandom), i == NCAP + 1);
		wait_idle();

		// receiver holds off while several batches queue up behind it
		hold_len = 3000;
		hold_req++;
		batch(3, 3000);
		batch(2, 2000);
		batch(4, 3000);
		batch(3, 3000);
		wait_idle();

		for (int ph = 0; ph < 5; ph++) begin
			idle_pct = (ph == 2) ? 0 : $urandom_range(10, 40);
			all_regs(24'($urandom_range(300000, 2500000)), $urandom_range(100000, 2000000),
				1'($urandom), $urandom, $urandom, $urandom, 31'($urandom), $urandom);
			random_batches(18);
			wait_idle();
		end

		// closing stretch with no idling on either side
		idle_pct = 0;
		all_regs(24'd1572864, 32'd409600, 1'b1, 32'hfffe_1c00, 32'h0000_4000, 32'hffff_c000,
			31'd70000, 32'h0200_0000);
		random_batches(20);
		wait_idle();

		$display("%0d particles in %0d batches, %0d results checked, %0d register settings",
			n_items, n_batches, n_results, n_settings);
		$display("covered 2d/3d, coincident and wrapped pairs, capacity drop, saturation");
		if (errors == 0 && expected_q.size() == 0) begin
			$display("lj_pair_force_pbc_tb passed");
		end else begin
			$display("%0d mismatches, %0d results never seen", errors, expected_q.size());
			$display("lj_pair_force_pbc_tb failed");
		end
		$finish;
	end

endmodule

/* lj_pair_force_pbc.f */
src/ljp_pkg.sv
src/ljp_fifo.sv
src/ljp_front.sv
src/ljp_back.sv
src/lj_pair_force_pbc.sv
tb/sv/lj_pair_force_pbc_tb.sv
